/* rtl/ffra_pkg.sv */
// Package for the first-fit range allocator: sizes, field widths, types and codes.
// No dependencies; used by the allocator RTL and its testbench.
package ffra_pkg;

  localparam int MEM_UNITS  = 128;
  localparam int MAX_RANGES = 64;

  localparam int ADDR_W = 7;
  localparam int SIZE_W = 8;
  localparam int SUM_W  = SIZE_W + 1;
  localparam int IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W  = $clog2(MAX_RANGES + 1);

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;

  localparam logic [ADDR_W-1:0] LAST_UNIT = ADDR_W'(MEM_UNITS - 1);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] first;
  } range_t;

  localparam int RANGE_W = $bits(range_t);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_SHIFT,
    ST_CHECK,
    ST_MERGE,
    ST_RESP
  } state_t;

endpackage

/* rtl/ffra_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies; read data holds while the read enable is low.
module ffra_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/first_fit_range_allocator.sv */
// First-fit range allocator: one item at a time; the free-range table sits in one RAM.
// Allocate: entries are read in order until one fits; a longer range is trimmed at its front,
// an exact fit shifts the later entries down to close the gap, and a miss reads every entry.
// Free: one merge pass, after a read-only adjacency pass with a full table (dropped if no merge).
// Reset: range count goes to one, then one cycle writes entry 0 (whole memory) before ready.
// Depends on ffra_pkg and ffra_ram.
module first_fit_range_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffra_pkg::S_DATA_W-1:0] s_tdata,  // block_size [7:0], free_address [14:8]
  input  logic                          s_tuser,  // req_type [0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffra_pkg::M_DATA_W-1:0] m_tdata,  // granted_address [6:0]
  output logic                          m_tuser   // ok [0]
);

  ffra_pkg::state_t state, state_next;

  logic [ffra_pkg::CNT_W-1:0]  count, count_next;
  logic [ffra_pkg::CNT_W-1:0]  rd_ptr, rd_ptr_next;
  logic [ffra_pkg::CNT_W-1:0]  wr_ptr, wr_ptr_next;
  logic                        q_ok, q_ok_next;
  logic                        inserted, inserted_next;
  logic                        cur_valid, cur_valid_next;
  logic                        merged_any, merged_any_next;
  ffra_pkg::range_t            cur, cur_next;
  logic [ffra_pkg::SIZE_W-1:0] size_q, size_q_next;
  logic [ffra_pkg::ADDR_W-1:0] addr_q, addr_q_next;
  logic [ffra_pkg::ADDR_W-1:0] hi_q, hi_q_next;
  logic [ffra_pkg::ADDR_W-1:0] res_addr, res_addr_next;
  logic                        res_ok, res_ok_next;
  logic                        out_valid, out_valid_next;
  logic [ffra_pkg::ADDR_W-1:0] out_addr, out_addr_next;
  logic                        out_ok, out_ok_next;

  logic                                  mem_we, mem_re;
  logic [ffra_pkg::IDX_W-1:0]            mem_waddr, mem_raddr;
  ffra_pkg::range_t                      mem_wdata;
  logic [ffra_pkg::RANGE_W-1:0]          mem_rdata;
  ffra_pkg::range_t                      q_rng, new_rng, elem;

  logic [ffra_pkg::SIZE_W-1:0] in_size;
  logic [ffra_pkg::ADDR_W-1:0] in_addr;
  logic [ffra_pkg::SUM_W-1:0]  hi_sum;
  logic [ffra_pkg::ADDR_W-1:0] hi_sat;
  logic [ffra_pkg::SIZE_W-1:0] len;
  logic                        take_q, take_new, stream_end, issue, adj;

  ffra_ram #(
    .WIDTH(ffra_pkg::RANGE_W),
    .DEPTH(ffra_pkg::MAX_RANGES)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign s_tready = (state == ffra_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_addr};
  assign m_tuser  = out_ok;

  assign in_size = s_tdata[ffra_pkg::SIZE_W-1:0];
  assign in_addr = s_tdata[ffra_pkg::SIZE_W +: ffra_pkg::ADDR_W];
  assign hi_sum  = ffra_pkg::SUM_W'(in_addr) + ffra_pkg::SUM_W'(in_size) - ffra_pkg::SUM_W'(1);
  assign hi_sat  = (hi_sum > ffra_pkg::SUM_W'(ffra_pkg::LAST_UNIT)) ? ffra_pkg::LAST_UNIT
                                                                     : hi_sum[ffra_pkg::ADDR_W-1:0];

  assign q_rng   = ffra_pkg::range_t'(mem_rdata);
  assign new_rng = '{last: hi_q, first: addr_q};
  assign len     = ffra_pkg::SIZE_W'(q_rng.last) - ffra_pkg::SIZE_W'(q_rng.first)
                   + ffra_pkg::SIZE_W'(1);

  assign take_q     = q_ok && (inserted || (q_rng.first <= addr_q));
  assign take_new   = !take_q && !inserted && (q_ok || (rd_ptr == count));
  assign stream_end = !q_ok && inserted && (rd_ptr == count);
  assign issue      = (rd_ptr < count) && (!q_ok || take_q);
  assign elem       = take_q ? q_rng : new_rng;
  assign adj        = cur_valid && ((ffra_pkg::SUM_W'(cur.last) + ffra_pkg::SUM_W'(1))
                                    == ffra_pkg::SUM_W'(elem.first));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffra_pkg::ST_INIT;
      count     <= ffra_pkg::CNT_W'(1);
      out_valid <= 1'b0;
      q_ok      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      q_ok      <= q_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    wr_ptr     <= wr_ptr_next;
    inserted   <= inserted_next;
    cur_valid  <= cur_valid_next;
    merged_any <= merged_any_next;
    cur        <= cur_next;
    size_q     <= size_q_next;
    addr_q     <= addr_q_next;
    hi_q       <= hi_q_next;
    res_addr   <= res_addr_next;
    res_ok     <= res_ok_next;
    out_addr   <= out_addr_next;
    out_ok     <= out_ok_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    q_ok_next       = q_ok;
    inserted_next   = inserted;
    cur_valid_next  = cur_valid;
    merged_any_next = merged_any;
    cur_next        = cur;
    size_q_next     = size_q;
    addr_q_next     = addr_q;
    hi_q_next       = hi_q;
    res_addr_next   = res_addr;
    res_ok_next     = res_ok;
    out_valid_next  = out_valid && !m_tready;
    out_addr_next   = out_addr;
    out_ok_next     = out_ok;
    mem_we          = 1'b0;
    mem_waddr       = wr_ptr[ffra_pkg::IDX_W-1:0];
    mem_wdata       = cur;
    mem_re          = 1'b0;
    mem_raddr       = rd_ptr[ffra_pkg::IDX_W-1:0];

    unique case (state)
      ffra_pkg::ST_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = '{last: ffra_pkg::LAST_UNIT, first: '0};
        state_next = ffra_pkg::ST_IDLE;
      end

      ffra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          size_q_next     = in_size;
          addr_q_next     = in_addr;
          hi_q_next       = hi_sat;
          res_addr_next   = '0;
          res_ok_next     = 1'b0;
          inserted_next   = 1'b0;
          cur_valid_next  = 1'b0;
          merged_any_next = 1'b0;
          wr_ptr_next     = '0;
          rd_ptr_next     = '0;
          q_ok_next       = 1'b0;
          if (s_tuser == ffra_pkg::REQ_ALLOC) begin
            if (count == '0) begin
              state_next = ffra_pkg::ST_RESP;
            end else begin
              mem_re      = 1'b1;
              mem_raddr   = '0;
              rd_ptr_next = ffra_pkg::CNT_W'(1);
              q_ok_next   = 1'b1;
              state_next  = ffra_pkg::ST_ALLOC;
            end
          end else if (in_size == '0) begin
            res_ok_next = 1'b1;
            state_next  = ffra_pkg::ST_RESP;
          end else if (ffra_pkg::SUM_W'(in_addr) >= ffra_pkg::SUM_W'(ffra_pkg::MEM_UNITS)) begin
            state_next = ffra_pkg::ST_RESP;
          end else begin
            if (count != '0) begin
              mem_re      = 1'b1;
              mem_raddr   = '0;
              rd_ptr_next = ffra_pkg::CNT_W'(1);
              q_ok_next   = 1'b1;
            end
            state_next = (count == ffra_pkg::CNT_W'(ffra_pkg::MAX_RANGES)) ?
                         ffra_pkg::ST_CHECK : ffra_pkg::ST_MERGE;
          end
        end
      end

      ffra_pkg::ST_ALLOC: begin
        if (len > size_q) begin
          mem_we        = 1'b1;
          mem_waddr     = rd_ptr[ffra_pkg::IDX_W-1:0] - ffra_pkg::IDX_W'(1);
          mem_wdata     = '{last: q_rng.last,
                            first: q_rng.first + size_q[ffra_pkg::ADDR_W-1:0]};
          res_addr_next = q_rng.first;
          res_ok_next   = 1'b1;
          q_ok_next     = 1'b0;
          state_next    = ffra_pkg::ST_RESP;
        end else if (len == size_q) begin
          res_addr_next = q_rng.first;
          res_ok_next   = 1'b1;
          wr_ptr_next   = rd_ptr - ffra_pkg::CNT_W'(1);
          if (rd_ptr < count) begin
            mem_re      = 1'b1;
            rd_ptr_next = rd_ptr + ffra_pkg::CNT_W'(1);
          end else begin
            q_ok_next = 1'b0;
          end
          state_next = ffra_pkg::ST_SHIFT;
        end else if (rd_ptr < count) begin
          mem_re      = 1'b1;
          rd_ptr_next = rd_ptr + ffra_pkg::CNT_W'(1);
        end else begin
          q_ok_next  = 1'b0;
          state_next = ffra_pkg::ST_RESP;
        end
      end

      ffra_pkg::ST_SHIFT: begin
        if (q_ok) begin
          mem_we      = 1'b1;
          mem_wdata   = q_rng;
          wr_ptr_next = wr_ptr + ffra_pkg::CNT_W'(1);
          if (rd_ptr < count) begin
            mem_re      = 1'b1;
            rd_ptr_next = rd_ptr + ffra_pkg::CNT_W'(1);
          end else begin
            q_ok_next = 1'b0;
          end
        end else begin
          count_next = count - ffra_pkg::CNT_W'(1);
          state_next = ffra_pkg::ST_RESP;
        end
      end

      ffra_pkg::ST_CHECK: begin
        if (take_q || take_new) begin
          mem_re          = issue;
          rd_ptr_next     = issue ? rd_ptr + ffra_pkg::CNT_W'(1) : rd_ptr;
          q_ok_next       = issue || (q_ok && !take_q);
          inserted_next   = inserted || take_new;
          merged_any_next = merged_any || adj;
          cur_next        = elem;
          cur_valid_next  = 1'b1;
        end else if (stream_end) begin
          if (merged_any) begin
            mem_re         = 1'b1;
            mem_raddr      = '0;
            rd_ptr_next    = ffra_pkg::CNT_W'(1);
            q_ok_next      = 1'b1;
            inserted_next  = 1'b0;
            cur_valid_next = 1'b0;
            wr_ptr_next    = '0;
            state_next     = ffra_pkg::ST_MERGE;
          end else begin
            state_next = ffra_pkg::ST_RESP;
          end
        end else begin
          mem_re      = issue;
          rd_ptr_next = issue ? rd_ptr + ffra_pkg::CNT_W'(1) : rd_ptr;
          q_ok_next   = issue || q_ok;
        end
      end

      ffra_pkg::ST_MERGE: begin
        if (take_q || take_new) begin
          mem_re         = issue;
          rd_ptr_next    = issue ? rd_ptr + ffra_pkg::CNT_W'(1) : rd_ptr;
          q_ok_next      = issue || (q_ok && !take_q);
          inserted_next  = inserted || take_new;
          cur_valid_next = 1'b1;
          if (!cur_valid) begin
            cur_next = elem;
          end else if (adj) begin
            cur_next.last = elem.last;
          end else begin
            mem_we      = 1'b1;
            wr_ptr_next = wr_ptr + ffra_pkg::CNT_W'(1);
            cur_next    = elem;
          end
        end else if (stream_end) begin
          mem_we      = 1'b1;
          count_next  = wr_ptr + ffra_pkg::CNT_W'(1);
          res_ok_next = 1'b1;
          state_next  = ffra_pkg::ST_RESP;
        end else begin
          mem_re      = issue;
          rd_ptr_next = issue ? rd_ptr + ffra_pkg::CNT_W'(1) : rd_ptr;
          q_ok_next   = issue || q_ok;
        end
      end

      ffra_pkg::ST_RESP: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_addr_next  = res_addr;
          out_ok_next    = res_ok;
          state_next     = ffra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ffra_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ffra_pkg::CNT_W'(ffra_pkg::MAX_RANGES))
    else $error("range count beyond table depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("table read and write hit the same entry");

  a_merge_order: assert property (@(posedge clk) disable iff (rst)
    (state == ffra_pkg::ST_MERGE) |-> (wr_ptr <= rd_ptr))
    else $error("merge write pointer overtook read pointer");

  a_zero_free: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == ffra_pkg::REQ_FREE) &&
     (s_tdata[ffra_pkg::SIZE_W-1:0] == '0)) |=> ((state == ffra_pkg::ST_RESP) && res_ok))
    else $error("zero-size free not answered at once");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ffra_pkg::ST_RESP))
    else $error("result beat raised outside response step");

endmodule

/* tb/first_fit_range_allocator_test.sv */
// Self-checking testbench for first_fit_range_allocator: a shadow free-range table predicts
// each grant; a burst driver, a stalling receiver and a clocked monitor run around the block.
// Depends on ffra_pkg and the allocator RTL.
module first_fit_range_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAB_PLAN    = 0;
  localparam int TAB_CHECK   = 1;
  localparam int LIMIT       = 1000000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 700;
  localparam int DRAIN       = 300;

  typedef struct packed {
    logic                        req;
    logic [ffra_pkg::SIZE_W-1:0] size;
    logic [ffra_pkg::ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [ffra_pkg::ADDR_W-1:0] granted;
    logic                        ok;
  } grant_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ffra_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ffra_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tuser;

  // shadow tables: one steers stimulus, one checks accepted beats
  int unsigned range_lo [2][ffra_pkg::MAX_RANGES];
  int unsigned range_hi [2][ffra_pkg::MAX_RANGES];
  int unsigned range_cnt [2];

  request_t    pending [$];
  grant_t      grants_due [$];
  int unsigned live_addr [$];
  int unsigned live_size [$];
  int          total_items = 0;
  int          sent_beats = 0;
  int          errors = 0;
  int          cycles = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          stall_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  first_fit_range_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  function automatic void clear_table(input int tab);
    for (int i = 0; i < ffra_pkg::MAX_RANGES; i++) begin
      range_lo[tab][i] = 0;
      range_hi[tab][i] = 0;
    end
    range_hi[tab][0] = ffra_pkg::MEM_UNITS - 1;
    range_cnt[tab] = 1;
  endfunction

  function automatic grant_t serve_request(input int tab, input request_t rq);
    grant_t      g;
    int unsigned len, hi, pos, n, i;
    int unsigned ts [ffra_pkg::MAX_RANGES+1];
    int unsigned te [ffra_pkg::MAX_RANGES+1];
    logic        done;
    g = '0;
    done = 1'b0;
    if (rq.req == ffra_pkg::REQ_ALLOC) begin
      for (int k = 0; k < range_cnt[tab] && !done; k++) begin
        len = range_hi[tab][k] - range_lo[tab][k] + 1;
        if (len >= rq.size) begin
          g.granted = ffra_pkg::ADDR_W'(range_lo[tab][k]);
          g.ok = 1'b1;
          done = 1'b1;
          if (len > rq.size) begin
            range_lo[tab][k] += rq.size;
          end else begin
            for (int j = k; j + 1 < range_cnt[tab]; j++) begin
              range_lo[tab][j] = range_lo[tab][j+1];
              range_hi[tab][j] = range_hi[tab][j+1];
            end
            range_cnt[tab]--;
          end
        end
      end
    end else if (rq.size == 0) begin
      g.ok = 1'b1;
    end else if (rq.addr < ffra_pkg::MEM_UNITS) begin
      hi = rq.addr + rq.size - 1;
      if (hi > ffra_pkg::MEM_UNITS - 1) hi = ffra_pkg::MEM_UNITS - 1;
      n = range_cnt[tab];
      pos = n;
      for (int k = n - 1; k >= 0; k--) begin
        if (range_lo[tab][k] > rq.addr) pos = k;
      end
      for (int k = 0; k <= n; k++) begin
        if (k < pos) begin
          ts[k] = range_lo[tab][k];
          te[k] = range_hi[tab][k];
        end else if (k == pos) begin
          ts[k] = rq.addr;
          te[k] = hi;
        end else begin
          ts[k] = range_lo[tab][k-1];
          te[k] = range_hi[tab][k-1];
        end
      end
      n++;
      i = 0;
      while (i + 1 < n) begin
        if (te[i] + 1 == ts[i+1]) begin
          te[i] = te[i+1];
          for (int j = i + 1; j + 1 < n; j++) begin
            ts[j] = ts[j+1];
            te[j] = te[j+1];
          end
          n--;
        end else begin
          i++;
        end
      end
      if (n <= ffra_pkg::MAX_RANGES) begin
        for (int k = 0; k < n; k++) begin
          range_lo[tab][k] = ts[k];
          range_hi[tab][k] = te[k];
        end
        range_cnt[tab] = n;
        g.ok = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic queue_request(input logic req, input int unsigned size,
                               input int unsigned addr, output grant_t g);
    request_t rq;
    rq.req  = req;
    rq.size = ffra_pkg::SIZE_W'(size);
    rq.addr = ffra_pkg::ADDR_W'(addr);
    g = serve_request(TAB_PLAN, rq);
    pending.push_back(rq);
  endtask

  task automatic release_live(input int idx);
    grant_t g;
    queue_request(ffra_pkg::REQ_FREE, live_size[idx], live_addr[idx], g);
    live_addr.delete(idx);
    live_size.delete(idx);
  endtask

  task automatic build_stimulus();
    grant_t      g;
    int unsigned order [$];
    int unsigned pick, size, tmp, j;
    // edge cases from reset, ending with the whole memory free again
    queue_request(ffra_pkg::REQ_ALLOC, 0,   0,  g);
    queue_request(ffra_pkg::REQ_ALLOC, 128, 0,  g);
    queue_request(ffra_pkg::REQ_ALLOC, 0,   0,  g);
    queue_request(ffra_pkg::REQ_ALLOC, 1,   0,  g);
    queue_request(ffra_pkg::REQ_FREE,  0,   5,  g);
    queue_request(ffra_pkg::REQ_FREE,  128, 127, g);
    queue_request(ffra_pkg::REQ_FREE,  64,  0,  g);
    queue_request(ffra_pkg::REQ_ALLOC, 100, 0,  g);
    queue_request(ffra_pkg::REQ_ALLOC, 64,  0,  g);
    queue_request(ffra_pkg::REQ_FREE,  63,  64, g);
    queue_request(ffra_pkg::REQ_FREE,  32,  0,  g);
    queue_request(ffra_pkg::REQ_FREE,  8,   0,  g);
    queue_request(ffra_pkg::REQ_ALLOC, 32,  99, g);
    queue_request(ffra_pkg::REQ_ALLOC, 8,   0,  g);
    queue_request(ffra_pkg::REQ_FREE,  32,  32, g);
    queue_request(ffra_pkg::REQ_FREE,  16,  0,  g);
    queue_request(ffra_pkg::REQ_FREE,  16,  16, g);
    queue_request(ffra_pkg::REQ_ALLOC, 127, 0,  g);
    queue_request(ffra_pkg::REQ_FREE,  127, 0,  g);

    // fragment memory into single units until the table is full
    do begin
      queue_request(ffra_pkg::REQ_ALLOC, 1, $urandom_range(0, 127), g);
    end while (g.ok);
    for (int a = 0; a < ffra_pkg::MEM_UNITS; a += 2) order.push_back(a);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) queue_request(ffra_pkg::REQ_FREE, 1, order[k], g);
    queue_request(ffra_pkg::REQ_ALLOC, 2, 0, g);
    queue_request(ffra_pkg::REQ_FREE, 1, 2 * $urandom_range(0, 63), g);
    queue_request(ffra_pkg::REQ_FREE, 1 + $urandom_range(0, 127), 2 * $urandom_range(0, 63), g);
    order.delete();
    for (int a = 1; a < ffra_pkg::MEM_UNITS; a += 2) order.push_back(a);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) queue_request(ffra_pkg::REQ_FREE, 1, order[k], g);

    // allocate and release live blocks, with a little noise
    for (int n = 0; n < 820; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        case ($urandom_range(0, 3))
          0: queue_request(ffra_pkg::REQ_ALLOC, 0, $urandom_range(0, 127), g);
          1: queue_request(ffra_pkg::REQ_ALLOC, $urandom_range(0, 128),
                           $urandom_range(0, 127), g);
          2: queue_request(ffra_pkg::REQ_FREE, $urandom_range(0, 128),
                           $urandom_range(0, 127), g);
          default: queue_request(ffra_pkg::REQ_FREE, 0, $urandom_range(0, 127), g);
        endcase
      end else if (pick < 52 || live_addr.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) size = $urandom_range(1, 8);
        else if (pick < 95) size = $urandom_range(9, 40);
        else size = $urandom_range(41, 128);
        queue_request(ffra_pkg::REQ_ALLOC, size, $urandom_range(0, 127), g);
        if (g.ok) begin
          live_addr.push_back(g.granted);
          live_size.push_back(size);
        end
      end else begin
        release_live($urandom_range(0, live_addr.size() - 1));
      end
      if (n % 200 == 199) begin
        while (live_addr.size() > 0) release_live($urandom_range(0, live_addr.size() - 1));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) sent_beats <= sent_beats + 1;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        request_t rq;
        rq = pending.pop_front();
        s_tdata  <= {1'b0, rq.addr, rq.size};
        s_tuser  <= rq.req;
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // hold off the receiver once, long enough for the input to back up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sent_beats >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stall_mode == 1 && $urandom_range(0, 7) == 0) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 14);
      end else if (stall_mode == 2 && $urandom_range(0, 1) == 0) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        request_t rq;
        rq.req  = s_tuser;
        rq.size = s_tdata[ffra_pkg::SIZE_W-1:0];
        rq.addr = s_tdata[ffra_pkg::SIZE_W +: ffra_pkg::ADDR_W];
        grants_due.push_back(serve_request(TAB_CHECK, rq));
      end
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result beat: granted_address %0d ok %0d",
                 m_tdata[ffra_pkg::ADDR_W-1:0], m_tuser);
          errors++;
        end else begin
          grant_t g;
          g = grants_due.pop_front();
          if (m_tdata[ffra_pkg::ADDR_W-1:0] !== g.granted) begin
            $error("granted_address: expected %0d, got %0d", g.granted,
                   m_tdata[ffra_pkg::ADDR_W-1:0]);
            errors++;
          end
          if (m_tuser !== g.ok) begin
            $error("ok: expected %0d, got %0d", g.ok, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("first_fit_range_allocator_test: FAIL");
      $finish;
    end
  end

  initial begin
    clear_table(TAB_PLAN);
    clear_table(TAB_CHECK);
    build_stimulus();
    total_items = pending.size();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (sent_beats < total_items || grants_due.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (grants_due.size() > 0) begin
      $error("%0d expected results never arrived", grants_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("first_fit_range_allocator_test: PASS");
    end else begin
      $display("first_fit_range_allocator_test: FAIL");
    end
    $finish;
  end

endmodule
